// File: rtl/core/msl_pkg.sv
// Package for the median-of-two-sorted-lists block.
// Holds the transfer payload types, the item kind codes and the default list depth.
// No dependencies.
package msl_pkg;

  // Default capacity of each list.
  localparam int DEFAULT_LIST_DEPTH = 256;

  // Item kind codes.
  localparam logic [1:0] KIND_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_APPEND_SECOND = 2'd1;
  localparam logic [1:0] KIND_FINISH        = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [32:0] median_doubled;
    logic               status;
    logic               overflow;
    logic [9:0]         total_count;
  } out_item_t;

endpackage

// File: rtl/core/median_of_two_sorted_lists.sv
// Median of two sorted lists: append items are accepted one per cycle, back to
// back, while idle. A finish transfer starts a merge walk, one step per cycle;
// the walk ends by loading the result into the output register, waiting while
// it still holds an unaccepted result, and input resumes with the load. Reset
// clears the counts, the drop flag and the output valid; the list RAMs are not
// cleared and need no clearing pass.
module median_of_two_sorted_lists #(
  parameter int LIST_DEPTH = msl_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  msl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output msl_pkg::out_item_t out_data
);
  import msl_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int TW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                     state_r, state_nxt;
  logic [CW-1:0]            cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]            cnt_b_r, cnt_b_nxt;
  logic                     drop_r, drop_nxt;
  logic [CW-1:0]            ptr_a_r, ptr_a_nxt;
  logic [CW-1:0]            ptr_b_r, ptr_b_nxt;
  logic [TW-1:0]            step_r, step_nxt;
  logic [TW-1:0]            lo_pos_r, hi_pos_r;
  logic                     empty_r;
  logic signed [31:0]       lo_val_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic                     in_xfer;
  logic                     app_a, app_b, finish;
  logic                     wr_en_a, wr_en_b;
  logic [TW-1:0]            total;
  logic [31:0]              rd_a_raw, rd_b_raw;
  logic signed [31:0]       rd_a, rd_b, cur, lo_sel;
  logic                     take_a, at_lo, at_hi, last, slot_free, advance, done;
  logic signed [32:0]       sum;

  // Input handshake and item decode.
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign app_a    = in_xfer && (in_data.kind == KIND_APPEND_FIRST);
  assign app_b    = in_xfer && (in_data.kind == KIND_APPEND_SECOND);
  assign finish   = in_xfer && (in_data.kind == KIND_FINISH);
  assign wr_en_a  = app_a && (cnt_a_r != DEPTH_C);
  assign wr_en_b  = app_b && (cnt_b_r != DEPTH_C);
  assign total    = {1'b0, cnt_a_r} + {1'b0, cnt_b_r};

  // List storage; reads are addressed by the next pointer values.
  msl_list_ram #(.DEPTH(LIST_DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (in_data.value),
    .rd_addr (ptr_a_nxt[AW-1:0]),
    .rd_data (rd_a_raw)
  );

  msl_list_ram #(.DEPTH(LIST_DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (in_data.value),
    .rd_addr (ptr_b_nxt[AW-1:0]),
    .rd_data (rd_b_raw)
  );

  assign rd_a = $signed(rd_a_raw);
  assign rd_b = $signed(rd_b_raw);

  // One merge step: take the first list when the second is used up or its head is strictly smaller.
  assign take_a    = (ptr_a_r < cnt_a_r) && ((ptr_b_r >= cnt_b_r) || (rd_a < rd_b));
  assign cur       = take_a ? rd_a : rd_b;
  assign at_lo     = (step_r == lo_pos_r);
  assign at_hi     = (step_r == hi_pos_r);
  assign last      = empty_r || at_hi;
  assign slot_free = !out_valid_r || out_ready;
  assign advance   = (state_r == ST_WALK) && (!last || slot_free);
  assign done      = (state_r == ST_WALK) && last && slot_free;
  assign lo_sel    = at_lo ? cur : lo_val_r;
  assign sum       = {lo_sel[31], lo_sel} + {cur[31], cur};

  // Next-state logic for the walk and the list counts.
  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    drop_nxt  = drop_r;
    ptr_a_nxt = ptr_a_r;
    ptr_b_nxt = ptr_b_r;
    step_nxt  = step_r;
    if (wr_en_a) begin
      cnt_a_nxt = cnt_a_r + 1'b1;
    end
    if (wr_en_b) begin
      cnt_b_nxt = cnt_b_r + 1'b1;
    end
    if ((app_a && !wr_en_a) || (app_b && !wr_en_b)) begin
      drop_nxt = 1'b1;
    end
    if (finish) begin
      state_nxt = ST_WALK;
      ptr_a_nxt = '0;
      ptr_b_nxt = '0;
      step_nxt  = '0;
    end
    if (advance && !done) begin
      step_nxt = step_r + 1'b1;
      if (take_a) begin
        ptr_a_nxt = ptr_a_r + 1'b1;
      end else begin
        ptr_b_nxt = ptr_b_r + 1'b1;
      end
    end
    if (done) begin
      state_nxt = ST_IDLE;
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      drop_nxt  = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      drop_r      <= 1'b0;
      ptr_a_r     <= '0;
      ptr_b_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      drop_r  <= drop_nxt;
      ptr_a_r <= ptr_a_nxt;
      ptr_b_r <= ptr_b_nxt;
      step_r  <= step_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk bounds and the lower middle value.
  always_ff @(posedge clk) begin
    if (finish) begin
      lo_pos_r <= (total - 1'b1) >> 1;
      hi_pos_r <= total >> 1;
      empty_r  <= (total == '0);
    end
    if (advance && at_lo) begin
      lo_val_r <= cur;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r.median_doubled <= empty_r ? '0 : sum;
      out_data_r.status         <= empty_r;
      out_data_r.overflow       <= drop_r;
      out_data_r.total_count    <= 10'(total);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/msl_list_ram.sv
// Storage for one list: a single-port-write, single-port-read synchronous RAM.
// Read data is registered. Depends on nothing else.
module msl_list_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
